// File: rtl/msfl_pkg.sv
// msfl_pkg: sizes, codes and the queued operation type of the shared-store stacks
// used by msfl_front, msfl_back, the top level and the checker
`default_nettype none

package msfl_pkg;

    localparam int NUM_STACKS = 4;
    localparam int DEPTH      = 16;

    localparam int DATA_W = 32;
    localparam int SID_W  = 2;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    // one code past the last slot is the null link
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int STK_W  = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    localparam logic [PTR_W-1:0] NULL_LINK = PTR_W'(DEPTH);

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BAD_ID    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        KIND_PUSH = 2'd0,
        KIND_POP  = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [STK_W-1:0]  sid;
        logic [DATA_W-1:0] value;
    } t_op;

endpackage

`default_nettype wire

// File: rtl/msfl_front.sv
// msfl_front: takes input words, checks the stack number and queues the operation
// depends on msfl_pkg
`default_nettype none

module msfl_front
    import msfl_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_command,
    input  wire logic [SID_W-1:0]         i_stack_id,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    output logic                          o_q_valid,
    output t_op                           o_q_op,
    input  wire logic                     i_q_ready
);

    t_op              r_q [Q_DEPTH];
    logic [QP_W-1:0]  r_wr_ptr;
    logic [QP_W-1:0]  r_rd_ptr;
    logic [QC_W-1:0]  r_cnt;
    logic [QC_W-1:0]  n_cnt;
    t_op              w_op;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        w_op.sid   = STK_W'(i_stack_id);
        w_op.value = i_push_value;
        if (int'(i_stack_id) >= NUM_STACKS) begin
            w_op.kind = KIND_BAD;
        end else if (t_cmd'(i_command) == CMD_POP) begin
            w_op.kind = KIND_POP;
        end else begin
            w_op.kind = KIND_PUSH;
        end
    end

    assign o_in_ready = (r_cnt != QC_W'(Q_DEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign o_q_op     = r_q[r_rd_ptr];
    assign w_push     = i_in_valid && o_in_ready;
    assign w_pop      = o_q_valid && i_q_ready;

    always_comb begin
        n_cnt = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_pop && !w_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_op;
        end
    end

endmodule

`default_nettype wire

// File: rtl/msfl_back.sv
// msfl_back: carries out push and pop on the linked slot store and holds the result word
// depends on msfl_pkg
`default_nettype none

module msfl_back
    import msfl_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_q_valid,
    input  wire t_op                      i_q_op,
    output logic                          o_q_ready,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [1:0]                    o_status,
    output logic signed [DATA_W-1:0]      o_popped_value
);

    logic [DATA_W-1:0] r_data [DEPTH];
    logic [PTR_W-1:0]  r_link [DEPTH];
    logic [PTR_W-1:0]  r_top  [NUM_STACKS];
    logic [PTR_W-1:0]  r_free_head;
    logic              r_out_valid;
    t_status           r_status;
    logic [DATA_W-1:0] r_popped;

    logic              w_take;
    logic [PTR_W-1:0]  w_top;
    logic [IDX_W-1:0]  w_link_addr;
    logic [PTR_W-1:0]  w_link;
    logic [DATA_W-1:0] w_data;
    logic              w_push_ok;
    logic              w_pop_ok;
    t_status           n_status;
    logic [DATA_W-1:0] n_popped;

    assign o_q_ready = !r_out_valid || i_out_ready;
    assign w_take    = i_q_valid && o_q_ready;

    // one link read per operation: free head for a push, stack top for a pop
    assign w_top       = r_top[i_q_op.sid];
    assign w_link_addr = (i_q_op.kind == KIND_PUSH) ? r_free_head[IDX_W-1:0]
                                                    : w_top[IDX_W-1:0];
    assign w_link      = r_link[w_link_addr];
    assign w_data      = r_data[w_top[IDX_W-1:0]];

    always_comb begin
        w_push_ok = 1'b0;
        w_pop_ok  = 1'b0;
        n_status  = ST_OK;
        n_popped  = '0;
        unique case (i_q_op.kind)
            KIND_PUSH: begin
                if (r_free_head >= NULL_LINK) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    w_push_ok = 1'b1;
                end
            end
            KIND_POP: begin
                if (w_top >= NULL_LINK) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    w_pop_ok = 1'b1;
                    n_popped = w_data;
                end
            end
            default: begin
                n_status = ST_BAD_ID;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_free_head <= '0;
            for (int i = 0; i < NUM_STACKS; i++) begin
                r_top[i] <= NULL_LINK;
            end
            // free list runs through every slot in order
            for (int i = 0; i < DEPTH; i++) begin
                r_link[i] <= PTR_W'(i + 1);
            end
        end else begin
            if (w_take) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_take && w_push_ok) begin
                r_free_head                    <= w_link;
                r_link[r_free_head[IDX_W-1:0]] <= w_top;
                r_top[i_q_op.sid]              <= r_free_head;
            end else if (w_take && w_pop_ok) begin
                r_top[i_q_op.sid]        <= w_link;
                r_link[w_top[IDX_W-1:0]] <= r_free_head;
                r_free_head              <= w_top;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
        if (w_take && w_push_ok) begin
            r_data[r_free_head[IDX_W-1:0]] <= i_q_op.value;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_status;
    assign o_popped_value = r_popped;

endmodule

`default_nettype wire

// File: rtl/multi_stack_shared_free_list.sv
// channel | handshake              | payload
// --------+------------------------+-------------------------------------------
// in      | i_in_valid / o_in_ready | i_command, i_stack_id, i_push_value
// out     | o_out_valid / i_out_ready | o_status, o_popped_value
//
// one word per cycle sustained while the output is not stalled
// the front holds a two-word queue, the back a one-word output register
// a word passes the queue register, then the back updates the store and result word at once
// reset (synchronous, active low) empties every stack and threads all slots on the free list
// a stalled output fills the queue, after which o_in_ready drops
//
// top level of the shared-store stacks; depends on msfl_pkg, msfl_front, msfl_back
`default_nettype none

module multi_stack_shared_free_list
    import msfl_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_command,
    input  wire logic [SID_W-1:0]         i_stack_id,
    input  wire logic signed [DATA_W-1:0] i_push_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [1:0]                    o_status,
    output logic signed [DATA_W-1:0]      o_popped_value
);

    logic q_valid;
    logic q_ready;
    t_op  q_op;

    msfl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_stack_id   (i_stack_id),
        .i_push_value (i_push_value),
        .o_q_valid    (q_valid),
        .o_q_op       (q_op),
        .i_q_ready    (q_ready)
    );

    msfl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_q_op         (q_op),
        .o_q_ready      (q_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_popped_value (o_popped_value)
    );

endmodule

`default_nettype wire

// File: rtl/msfl_checker.sv
// msfl_checker: port-level assertions for the shared-store stacks, bound to the top level
// depends on msfl_pkg
`default_nettype none

module msfl_checker
    import msfl_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_in_valid,
    input wire logic                     o_in_ready,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_ready,
    input wire logic [1:0]               o_status,
    input wire logic signed [DATA_W-1:0] o_popped_value
);

    // words taken in but not yet delivered
    logic [2:0] r_outst;
    logic       w_in_acc;
    logic       w_out_acc;

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outst <= '0;
        end else begin
            r_outst <= r_outst + 3'(w_in_acc) - 3'(w_out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_status) && $stable(o_popped_value))
        else $error("result word changed while stalled");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_outst != 3'd0)
        else $error("result word without a pending input");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_outst <= 3'(Q_DEPTH + 1))
        else $error("more words in flight than the block can hold");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_popped_value == '0)
        else $error("failed operation returned a nonzero value");

endmodule

bind multi_stack_shared_free_list msfl_checker u_msfl_checker (.*);

`default_nettype wire

// File: tb/tb_top.sv
// tb_top: self-checking bench for multi_stack_shared_free_list, pushes and pops on four stacks
// depends on msfl_pkg and the top level; predicts status and popped value of every word
`timescale 1ns / 100ps

module tb_top;
    import msfl_pkg::*;

    localparam int CYCLE_LIMIT = 100000;
    localparam int RAND_ITEMS  = 1930;
    localparam int IDLE_PCT    = 32;

    typedef struct {
        t_cmd                     cmd;
        logic [SID_W-1:0]         sid;
        logic signed [DATA_W-1:0] value;
        bit                       drain;
    } t_op_word;

    typedef struct {
        t_status                  status;
        logic signed [DATA_W-1:0] popped;
    } t_result;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_vld = 1'b0;
    logic                     in_rdy;
    logic                     cmd = 1'b0;
    logic [SID_W-1:0]         sid = '0;
    logic signed [DATA_W-1:0] push_val = '0;
    logic                     out_vld;
    logic                     out_rdy = 1'b0;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] popped_val;

    t_op_word op_q[$];
    t_result  result_q[$];

    // shadow copy of the slot store and its linked lists
    logic [DATA_W-1:0] shadow_data [DEPTH];
    logic [PTR_W-1:0]  shadow_link [DEPTH];
    logic [PTR_W-1:0]  shadow_top  [NUM_STACKS];
    logic [PTR_W-1:0]  shadow_free;

    int  sent_cnt = 0;
    int  taken_cnt = 0;
    int  total_ops = 0;
    int  cycles = 0;
    bit  failed = 1'b0;
    logic calm;

    multi_stack_shared_free_list i_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_vld),
        .o_in_ready     (in_rdy),
        .i_command      (cmd),
        .i_stack_id     (sid),
        .i_push_value   (push_val),
        .o_out_valid    (out_vld),
        .i_out_ready    (out_rdy),
        .o_status       (status),
        .o_popped_value (popped_val)
    );

    always #5 clk = ~clk;

    // no random idling on either side over this stretch
    assign calm = (sent_cnt >= 800) && (sent_cnt < 1100);

    function automatic void shadow_clear();
        for (int i = 0; i < DEPTH; i++) begin
            shadow_data[i] = '0;
            shadow_link[i] = (i + 1 < DEPTH) ? PTR_W'(i + 1) : NULL_LINK;
        end
        for (int s = 0; s < NUM_STACKS; s++) begin
            shadow_top[s] = NULL_LINK;
        end
        shadow_free = '0;
    endfunction

    function automatic void stack_apply(input t_op_word w);
        t_result          r;
        logic [PTR_W-1:0] slot;
        logic [IDX_W-1:0] idx;
        r.status = ST_OK;
        r.popped = '0;
        if (int'(w.sid) >= NUM_STACKS) begin
            r.status = ST_BAD_ID;
        end else if (w.cmd == CMD_PUSH) begin
            slot = shadow_free;
            if (slot >= PTR_W'(DEPTH)) begin
                r.status = ST_OVERFLOW;
            end else begin
                idx = slot[IDX_W-1:0];
                shadow_free = shadow_link[idx];
                shadow_data[idx] = w.value;
                shadow_link[idx] = shadow_top[w.sid];
                shadow_top[w.sid] = slot;
            end
        end else begin
            slot = shadow_top[w.sid];
            if (slot >= PTR_W'(DEPTH)) begin
                r.status = ST_UNDERFLOW;
            end else begin
                idx = slot[IDX_W-1:0];
                shadow_top[w.sid] = shadow_link[idx];
                r.popped = shadow_data[idx];
                shadow_link[idx] = shadow_free;
                shadow_free = slot;
            end
        end
        result_q.push_back(r);
    endfunction

    function automatic void add_op(input t_cmd c, input int s, input logic [DATA_W-1:0] v,
                                   input bit d);
        t_op_word w;
        w.cmd = c;
        w.sid = SID_W'(s);
        w.value = v;
        w.drain = d;
        op_q.push_back(w);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value(input int n);
        case (n % 7)
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return 32'h5555_5555;
            5: return 32'haaaa_aaaa;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // driver: a word stays on the bus until the monitor has seen it taken
    always @(negedge clk) begin
        if (!rst_n) begin
            in_vld <= 1'b0;
        end else if (!(in_vld && taken_cnt < sent_cnt)) begin
            if (op_q.size() == 0 || (op_q[0].drain && result_q.size() != 0) ||
                (!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
                in_vld <= 1'b0;
            end else begin
                in_vld   <= 1'b1;
                cmd      <= op_q[0].cmd;
                sid      <= op_q[0].sid;
                push_val <= op_q[0].value;
                void'(op_q.pop_front());
                sent_cnt++;
            end
        end
        out_rdy <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk) begin : monitor
        t_op_word w;
        t_result  r;
        if (rst_n) begin
            if (in_vld && in_rdy) begin
                w.cmd = t_cmd'(cmd);
                w.sid = sid;
                w.value = push_val;
                w.drain = 1'b0;
                stack_apply(w);
                taken_cnt++;
            end
            if (out_vld && out_rdy) begin
                if (result_q.size() == 0) begin
                    $error("unexpected word: status %0d popped_value %0d", status, popped_val);
                    failed = 1'b1;
                end else begin
                    r = result_q.pop_front();
                    if (status !== r.status) begin
                        $error("status: expected %0d, actual %0d", r.status, status);
                        failed = 1'b1;
                    end
                    if (popped_val !== r.popped) begin
                        $error("popped_value: expected %0d, actual %0d", r.popped, popped_val);
                        failed = 1'b1;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int   added;
        int   blk;
        int   push_pct;
        int   len;
        int   one_sid;
        bit   fixed_sid;
        int   s;
        t_cmd c;
        logic [DATA_W-1:0] v;

        shadow_clear();

        // directed: underflow, fill all slots (the first seven with edge values), overflow, then pops
        add_op(CMD_POP, 0, 32'h1234_5678, 1'b0);
        for (int i = 0; i < DEPTH; i++) begin
            add_op(CMD_PUSH, i % NUM_STACKS, (i < 7) ? pick_value(i) : $urandom(), 1'b0);
        end
        add_op(CMD_PUSH, 2, 32'hdead_beef, 1'b0);
        for (int i = 0; i < NUM_STACKS; i++) begin
            add_op(CMD_POP, i, $urandom(), 1'b0);
        end

        // random: bursts that lean toward filling or draining the store
        added = 0;
        blk = 0;
        while (added < RAND_ITEMS) begin
            case ($urandom_range(0, 3))
                0: push_pct = 15;
                1: push_pct = 50;
                2: push_pct = 70;
                default: push_pct = 90;
            endcase
            len = $urandom_range(10, 60);
            fixed_sid = ($urandom_range(0, 3) == 0);
            one_sid = $urandom_range(0, NUM_STACKS - 1);
            for (int k = 0; k < len; k++) begin
                c = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
                s = fixed_sid ? one_sid : $urandom_range(0, NUM_STACKS - 1);
                v = ($urandom_range(0, 7) == 0) ? pick_value($urandom()) : $urandom();
                // hold the sender until the block is empty at the start of some bursts
                add_op(c, s, v, (k == 0) && (blk == 5 || $urandom_range(0, 7) == 0));
                added++;
            end
            blk++;
        end
        total_ops = op_q.size();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (taken_cnt == total_ops);
        wait (result_q.size() == 0);
        repeat (8) @(posedge clk);
        if (!failed) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
